[rtl/nmea_sentence_validator_defines.svh]
// Assertion macros used by the verification-side checker of the sentence validator.
// Depends on nothing; the asserting scope supplies i_clk and i_rst_n.
`ifndef NMEA_SENTENCE_VALIDATOR_DEFINES_SVH
`define NMEA_SENTENCE_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define NSV_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define NSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nsv_pkg.sv]
// Package for the sentence validator: status codes, header bytes, hex decode.
// Depends on nothing; used by the top level and its checker.
package nsv_pkg;

    localparam int unsigned HDR_LEN = 6;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_NO_STAR    = 3'd2;
    localparam logic [2:0] ST_MISMATCH   = 3'd3;
    localparam logic [2:0] ST_FEW_FIELDS = 3'd4;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    localparam logic [7:0] MIN_FIELDS_RESET = 8'd16;

    // Expected header byte at a given position; positions past the header read zero.
    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h24;
            3'd1:    b = 8'h47;
            3'd2:    b = 8'h48;
            3'd3:    b = 8'h46;
            3'd4:    b = 8'h50;
            3'd5:    b = 8'h44;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

[rtl/nmea_sentence_validator.sv]
// Top level of the sentence validator: input register, per-byte update, result register.
// Depends on nsv_pkg.
//
// The block takes one sentence character per input beat and, on the beat
// flagged by tlast, delivers one status beat. It checks the six-byte header,
// XORs the bytes from the second one up to the first '*', needs at least two
// bytes after that '*', reads the hex digits after it (a value above 255
// mismatches) and counts the fields split on ',' and '*' against min_fields.
// Status codes: 0 ok, 1 bad header, 2 no star or short tail, 3 checksum
// mismatch, 4 too few fields; the first failing check in that order wins.
// Throughput is one beat per cycle unless a final byte must wait (below): every
// byte passes an input register and the combinational per-byte update logic,
// and final bytes load a result register, which presents the result on the
// output. Non-final bytes keep flowing while a result waits on the output;
// only a final byte waits in the input register until the result register
// is free.
// Write min_fields (reset 16) only while no sentence is in flight.
module nmea_sentence_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,     // min_fields
    // byte stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] data_byte
    input  logic        i_s_axis_tlast,    // last
    // status stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,    // [7:0] computed_checksum, [15:8] received_checksum,
                                           // [23:16] field_count
    output logic [3:0]  o_m_axis_tuser     // [2:0] status, [3] valid_res
);

    // configuration register
    logic [7:0] r_min_fields;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // sentence state
    logic [2:0] r_pos,  n_pos;
    logic       r_hdr_ok, n_hdr_ok;
    logic [7:0] r_xor,  n_xor;
    logic       r_star, n_star;
    logic [1:0] r_tail, n_tail;
    logic       r_hex_act, n_hex_act;
    logic [7:0] r_hex,  n_hex;
    logic       r_hex_over, n_hex_over;
    logic [7:0] r_fld,  n_fld;

    // result register
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic [3:0]  r_out_user;

    logic       in_take;
    logic       advance;
    logic [2:0] n_status;
    logic [4:0] dig;

    // A final byte may only move on when the result register is free or draining.
    assign advance = r_in_valid && !(r_in_last && r_out_valid && !i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take = i_s_axis_tvalid && o_s_axis_tready;

    // Per-byte update of the sentence state.
    always_comb begin
        n_pos      = r_pos;
        n_hdr_ok   = r_hdr_ok;
        n_xor      = r_xor;
        n_star     = r_star;
        n_tail     = r_tail;
        n_hex_act  = r_hex_act;
        n_hex      = r_hex;
        n_hex_over = r_hex_over;
        n_fld      = r_fld;
        dig        = nsv_pkg::hex_digit(r_in_byte);

        if (r_pos < 3'(nsv_pkg::HDR_LEN) && r_in_byte != nsv_pkg::hdr_byte(r_pos)) begin
            n_hdr_ok = 1'b0;
        end

        if (r_star) begin
            if (r_tail < 2'd2) begin
                n_tail = r_tail + 2'd1;
            end
            if (r_hex_act) begin
                if (!dig[4]) begin
                    n_hex_act = 1'b0;
                end else begin
                    // anything in the high nibble would be shifted past 8 bits
                    if (|r_hex[7:4]) begin
                        n_hex_over = 1'b1;
                    end
                    n_hex = {r_hex[3:0], dig[3:0]};
                end
            end
        end else if (r_in_byte == nsv_pkg::CHAR_STAR) begin
            n_star    = 1'b1;
            n_hex_act = 1'b1;
        end else if (r_pos != 3'd0) begin
            n_xor = r_xor ^ r_in_byte;
        end

        if ((r_in_byte == nsv_pkg::CHAR_COMMA || r_in_byte == nsv_pkg::CHAR_STAR)
            && r_fld != 8'hFF) begin
            n_fld = r_fld + 8'd1;
        end

        if (r_pos < 3'(nsv_pkg::HDR_LEN)) begin
            n_pos = r_pos + 3'd1;
        end

        // first failing check decides the status
        if (n_pos < 3'(nsv_pkg::HDR_LEN) || !n_hdr_ok) begin
            n_status = nsv_pkg::ST_BAD_HEADER;
        end else if (!n_star || n_tail < 2'd2) begin
            n_status = nsv_pkg::ST_NO_STAR;
        end else if (n_hex_over || n_hex != n_xor) begin
            n_status = nsv_pkg::ST_MISMATCH;
        end else if (n_fld < r_min_fields) begin
            n_status = nsv_pkg::ST_FEW_FIELDS;
        end else begin
            n_status = nsv_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fields <= nsv_pkg::MIN_FIELDS_RESET;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pos        <= 3'd0;
            r_hdr_ok     <= 1'b1;
            r_xor        <= 8'd0;
            r_star       <= 1'b0;
            r_tail       <= 2'd0;
            r_hex_act    <= 1'b0;
            r_hex        <= 8'd0;
            r_hex_over   <= 1'b0;
            r_fld        <= 8'd1;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_fields <= i_cfg_wr_data;
            end

            // input register: refill when empty or moving on
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end

            // drain the result register, then maybe reload it
            if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                if (r_in_last) begin
                    // hand off the result and clear for the next sentence
                    r_out_valid <= 1'b1;
                    r_pos       <= 3'd0;
                    r_hdr_ok    <= 1'b1;
                    r_xor       <= 8'd0;
                    r_star      <= 1'b0;
                    r_tail      <= 2'd0;
                    r_hex_act   <= 1'b0;
                    r_hex       <= 8'd0;
                    r_hex_over  <= 1'b0;
                    r_fld       <= 8'd1;
                end else begin
                    r_pos       <= n_pos;
                    r_hdr_ok    <= n_hdr_ok;
                    r_xor       <= n_xor;
                    r_star      <= n_star;
                    r_tail      <= n_tail;
                    r_hex_act   <= n_hex_act;
                    r_hex       <= n_hex;
                    r_hex_over  <= n_hex_over;
                    r_fld       <= n_fld;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (advance && r_in_last) begin
            r_out_data <= {n_fld, n_hex, n_xor};
            r_out_user <= {n_status == nsv_pkg::ST_OK, n_status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

[rtl/nsv_checker.sv]
// Port-level checker for the sentence validator, bound to the top level.
// Depends on nsv_pkg and nmea_sentence_validator_defines.svh.
`include "nmea_sentence_validator_defines.svh"

module nsv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser
);

    `NSV_ASSERT_IMPLY(a_status_range, o_m_axis_tvalid,
        o_m_axis_tuser[2:0] == nsv_pkg::ST_OK || o_m_axis_tuser[2:0] == nsv_pkg::ST_BAD_HEADER ||
        o_m_axis_tuser[2:0] == nsv_pkg::ST_NO_STAR || o_m_axis_tuser[2:0] == nsv_pkg::ST_MISMATCH ||
        o_m_axis_tuser[2:0] == nsv_pkg::ST_FEW_FIELDS, "status code out of range")

    `NSV_ASSERT_IMPLY(a_ok_flag, o_m_axis_tvalid,
        o_m_axis_tuser[3] == (o_m_axis_tuser[2:0] == nsv_pkg::ST_OK), "valid_res disagrees")

    `NSV_ASSERT_IMPLY(a_ok_sum, o_m_axis_tvalid && o_m_axis_tuser[3],
        o_m_axis_tdata[7:0] == o_m_axis_tdata[15:8] && o_m_axis_tdata[23:16] != 8'd0,
        "ok status with checksum mismatch or zero fields")

    `NSV_ASSERT_IMPLY(a_ready_when_empty, !o_m_axis_tvalid, o_s_axis_tready,
        "input stalled with no result pending")

    `NSV_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser),
        "stalled result beat changed")

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (.*);

[sim/nmea_sentence_validator_test.sv]
// Self-checking testbench for the sentence validator: streams sentence bytes in, checks status beats.
// Depends on nsv_pkg and nmea_sentence_validator; an internal predictor supplies expected beats.
`timescale 1ns / 1ps

module nmea_sentence_validator_test;

    // Sync header, first byte in the low bits.
    localparam logic [47:0] SYNC_HDR       = 48'h44_50_46_48_47_24;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_char_beat;

    typedef struct packed {
        logic [2:0] status;
        logic       ok;
        logic [7:0] calc_sum;
        logic [7:0] rcvd_sum;
        logic [7:0] nfields;
    } t_status_beat;

    typedef enum int {
        SN_GOOD, SN_BAD_HDR, SN_NO_STAR, SN_SHORT_TAIL, SN_BAD_SUM,
        SN_LONG_HEX, SN_EMPTY_HEX, SN_TRUNC, SN_NOISE
    } t_sentence_kind;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [7:0]  i_cfg_wr_data   = 8'd0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'd0;   // [7:0] data_byte
    logic        i_s_axis_tlast  = 1'b0;   // last
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;           // [7:0] computed, [15:8] received, [23:16] field count
    logic [3:0]  o_m_axis_tuser;           // [2:0] status, [3] valid_res

    nmea_sentence_validator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bytes waiting to be sent, and status beats the predictor has produced but not yet seen.
    t_char_beat   char_backlog[$];
    t_status_beat status_due[$];
    int           pushed_cnt   = 0;
    int           accepted_cnt = 0;
    int           errors       = 0;

    // Sentence-level predictor state plus its copy of min_fields.
    logic [7:0] min_fields_model = nsv_pkg::MIN_FIELDS_RESET;
    logic [2:0] sync_pos;
    logic       sync_good;
    logic [7:0] sum_acc;
    logic       star_hit;
    logic [1:0] tail_len;
    logic       hex_live;
    logic [7:0] hex_acc;
    logic       hex_big;
    logic [7:0] fields;

    // Handshake bookkeeping between the rising-edge sampler and the falling-edge drivers.
    bit         in_fired   = 1'b0;
    bit         calm       = 1'b0;   // no gaps on either side while set
    int         gap_left   = 0;
    int         stall_left = 0;
    int         quiet      = 0;
    int         cycle_cnt  = 0;
    t_char_beat next_beat;

    task automatic restart_sentence();
        sync_pos  = 3'd0;
        sync_good = 1'b1;
        sum_acc   = 8'd0;
        star_hit  = 1'b0;
        tail_len  = 2'd0;
        hex_live  = 1'b0;
        hex_acc   = 8'd0;
        hex_big   = 1'b0;
        fields    = 8'd1;
    endtask

    // Advance the sentence state by one accepted byte; on the final byte queue the status beat.
    task automatic absorb_char(input logic [7:0] c, input logic fin);
        t_status_beat r;
        logic [4:0]   d;
        // Header match only applies to the first six positions.
        if (sync_pos < nsv_pkg::HDR_LEN && c != SYNC_HDR[8*sync_pos +: 8]) begin
            sync_good = 1'b0;
        end
        if (star_hit) begin
            if (tail_len < 2'd2) begin
                tail_len++;
            end
            if (hex_live) begin
                // Bit 4 flags a digit; letters map via the low nibble plus nine.
                d = 5'd0;
                if (c >= 8'h30 && c <= 8'h39) begin
                    d = {1'b1, c[3:0]};
                end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
                    d = {1'b1, c[3:0] + 4'd9};
                end
                if (!d[4]) begin
                    hex_live = 1'b0;
                end else begin
                    // Anything already above one digit's worth overflows eight bits.
                    if (hex_acc >= 8'd16) begin
                        hex_big = 1'b1;
                    end
                    hex_acc = {hex_acc[3:0], d[3:0]};
                end
            end
        end else if (c == nsv_pkg::CHAR_STAR) begin
            star_hit = 1'b1;
            hex_live = 1'b1;
        end else if (sync_pos != 3'd0) begin
            sum_acc ^= c;
        end
        if ((c == nsv_pkg::CHAR_COMMA || c == nsv_pkg::CHAR_STAR) && fields != 8'hFF) begin
            fields++;
        end
        if (sync_pos < nsv_pkg::HDR_LEN) begin
            sync_pos++;
        end
        if (fin) begin
            // First failing check wins: header, star and tail, checksum, field count.
            if (sync_pos < nsv_pkg::HDR_LEN || !sync_good) begin
                r.status = nsv_pkg::ST_BAD_HEADER;
            end else if (!star_hit || tail_len < 2'd2) begin
                r.status = nsv_pkg::ST_NO_STAR;
            end else if (hex_big || hex_acc != sum_acc) begin
                r.status = nsv_pkg::ST_MISMATCH;
            end else if (fields < min_fields_model) begin
                r.status = nsv_pkg::ST_FEW_FIELDS;
            end else begin
                r.status = nsv_pkg::ST_OK;
            end
            r.ok       = (r.status == nsv_pkg::ST_OK);
            r.calc_sum = sum_acc;
            r.rcvd_sum = star_hit ? hex_acc : 8'd0;
            r.nfields  = fields;
            status_due = {status_due, r};
            restart_sentence();
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Mostly short gaps, a few long ones, none at all while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Sample both handshakes at the rising edge; predict first, then check, then the watchdog.
    always @(posedge i_clk) begin
        t_status_beat exp_beat;
        bit           moved;
        moved = 1'b0;
        cycle_cnt++;
        if (cycle_cnt % 256 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
        end
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            in_fired = 1'b1;
            moved    = 1'b1;
            accepted_cnt++;
            absorb_char(i_s_axis_tdata, i_s_axis_tlast);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            moved = 1'b1;
            if (status_due.size() == 0) begin
                errors++;
                $display("%0t: status beat with none expected, expected nothing, actual %h/%h",
                         $time, o_m_axis_tuser, o_m_axis_tdata);
            end else begin
                exp_beat = status_due.pop_front();
                check_field("status", exp_beat.status, o_m_axis_tuser[2:0]);
                check_field("valid_res", exp_beat.ok, o_m_axis_tuser[3]);
                check_field("computed_checksum", exp_beat.calc_sum, o_m_axis_tdata[7:0]);
                check_field("received_checksum", exp_beat.rcvd_sum, o_m_axis_tdata[15:8]);
                check_field("field_count", exp_beat.nfields, o_m_axis_tdata[23:16]);
            end
        end
        if (moved || i_cfg_wr_en || !i_rst_n) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, quiet);
            $display("FAILURE");
            $finish;
        end
    end

    // Sender: hold a beat until taken, then idle for its gap or load the next byte.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || in_fired)) begin
            in_fired = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (char_backlog.size() != 0) begin
                next_beat = char_backlog.pop_front();
                i_s_axis_tdata  <= next_beat.ch;
                i_s_axis_tlast  <= next_beat.fin;
                i_s_axis_tvalid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready for one cycle, then stall for a random stretch, which may be empty.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    task automatic push_char(input logic [7:0] c, input logic fin);
        t_char_beat b;
        b.ch  = c;
        b.fin = fin;
        char_backlog = {char_backlog, b};
        pushed_cnt++;
    endtask

    task automatic push_header();
        int k;
        for (k = 0; k < 6; k++) begin
            push_char(SYNC_HDR[8*k +: 8], 1'b0);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) begin
            return 8'h30 + v;
        end
        return (lower ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    // Field content: mostly printable, sometimes any byte; never a star.
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 4) != 0) begin
                c = 8'($urandom_range(8'h20, 8'h7E));
            end else begin
                c = 8'($urandom_range(0, 255));
            end
        end while (c == nsv_pkg::CHAR_STAR);
        return c;
    endfunction

    // Build one sentence of the given kind with random content and queue its bytes.
    task automatic queue_sentence(input t_sentence_kind kind, input int n_commas);
        logic [7:0] line[$];
        logic [7:0] sum;
        int         k;
        int         n;
        int         pos;
        bit         lower;
        lower = $urandom_range(0, 1);
        for (k = 0; k < 6; k++) begin
            line = {line, SYNC_HDR[8*k +: 8]};
        end
        if (kind == SN_NOISE) begin
            // Random junk, sometimes opening like a real sentence.
            line.delete();
            n = $urandom_range(1, 12);
            repeat (n) line = {line, 8'($urandom_range(0, 255))};
            if ($urandom_range(0, 1)) begin
                line[0] = SYNC_HDR[7:0];
            end
        end else if (kind == SN_TRUNC) begin
            n = $urandom_range(1, 5);
            while (line.size() > n) begin
                void'(line.pop_back());
            end
        end else begin
            if (kind == SN_BAD_HDR) begin
                pos = $urandom_range(0, 5);
                line[pos] = line[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            for (k = 0; k < n_commas; k++) begin
                line = {line, nsv_pkg::CHAR_COMMA};
                n = (n_commas > 40) ? 0 : $urandom_range(0, 3);
                repeat (n) line = {line, field_char()};
            end
            sum = 8'd0;
            for (k = 1; k < line.size(); k++) begin
                sum ^= line[k];
            end
            case (kind)
                SN_NO_STAR: begin
                    if ($urandom_range(0, 1)) begin
                        line = {line, field_char()};
                    end
                end
                SN_SHORT_TAIL: begin
                    line = {line, nsv_pkg::CHAR_STAR};
                    if ($urandom_range(0, 1)) begin
                        line = {line, hex_char(sum[7:4], lower)};
                    end
                end
                SN_LONG_HEX: begin
                    // Nonzero lead digit, three or four digits: overflows eight bits.
                    line = {line, nsv_pkg::CHAR_STAR};
                    line = {line, hex_char(4'($urandom_range(1, 15)), lower)};
                    repeat ($urandom_range(2, 3)) begin
                        line = {line, hex_char(4'($urandom_range(0, 15)), lower)};
                    end
                end
                SN_EMPTY_HEX: begin
                    // Star followed straight by non-hex bytes reads as zero.
                    line = {line, nsv_pkg::CHAR_STAR};
                    line = {line, 8'h0D};
                    line = {line, ($urandom_range(0, 1) ? 8'h0A : nsv_pkg::CHAR_COMMA)};
                end
                default: begin
                    if (kind == SN_BAD_SUM) begin
                        sum ^= 8'($urandom_range(1, 255));
                    end
                    line = {line, nsv_pkg::CHAR_STAR};
                    if ($urandom_range(0, 7) == 0) begin
                        line = {line, 8'h30};   // leading zero is legal
                    end
                    line = {line, hex_char(sum[7:4], lower)};
                    line = {line, hex_char(sum[3:0], lower)};
                    if ($urandom_range(0, 1)) begin
                        line = {line, 8'h0D};
                        line = {line, 8'h0A};
                    end
                end
            endcase
        end
        for (k = 0; k < line.size(); k++) begin
            push_char(line[k], k == line.size() - 1);
        end
    endtask

    // Random sentences until roughly the given number of bytes is queued.
    task automatic random_phase(input int budget);
        int             start;
        int             r;
        int             n_commas;
        t_sentence_kind kind;
        start = pushed_cnt;
        while (pushed_cnt - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 60)      kind = SN_GOOD;
            else if (r < 65) kind = SN_BAD_HDR;
            else if (r < 70) kind = SN_NO_STAR;
            else if (r < 75) kind = SN_SHORT_TAIL;
            else if (r < 82) kind = SN_BAD_SUM;
            else if (r < 87) kind = SN_LONG_HEX;
            else if (r < 90) kind = SN_EMPTY_HEX;
            else if (r < 94) kind = SN_TRUNC;
            else             kind = SN_NOISE;
            n_commas = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            queue_sentence(kind, n_commas);
        end
    endtask

    // Wait until every byte is taken and every status beat has come back, then let it settle.
    task automatic drain();
        while (accepted_cnt != pushed_cnt || status_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write min_fields with the block idle; the predictor follows.
    task automatic set_min_fields(input logic [7:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        min_fields_model = v;
    endtask

    initial begin
        restart_sentence();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short sentence with NUL and all-ones bytes, lower-case checksum,
        // checksum overflow, and a star with no hex digits.
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);
        push_header();
        push_char(nsv_pkg::CHAR_STAR, 1'b0);
        push_char(8'h35, 1'b0);
        push_char(8'h64, 1'b1);
        push_header();
        push_char(nsv_pkg::CHAR_STAR, 1'b0);
        push_char(8'h31, 1'b0);
        push_char(8'h35, 1'b0);
        push_char(8'h44, 1'b1);
        push_header();
        push_char(nsv_pkg::CHAR_STAR, 1'b0);
        push_char(8'h0D, 1'b0);
        push_char(8'h0A, 1'b1);

        random_phase(70);
        set_min_fields(8'd1);
        random_phase(70);

        // Top of range: only a saturated field count passes; shorter sentences fail.
        set_min_fields(8'd255);
        queue_sentence(SN_GOOD, 260);
        random_phase(30);

        // Zero minimum: every sentence meets it.
        set_min_fields(8'd0);
        random_phase(60);
        set_min_fields(8'($urandom_range(2, 24)));
        random_phase(60);
        set_min_fields(8'($urandom_range(2, 24)));
        random_phase(60);

        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
